FILE: rtl/msts_pkg.sv
`timescale 1ns / 1ps

package msts_pkg;

	// Test mode codes, also driven out as seq_mode
	typedef enum logic [2:0] {
		MODE_DISABLED = 3'd0,
		MODE_RUNNING  = 3'd1,
		MODE_STOPPING = 3'd2,
		MODE_RECOVER  = 3'd3,
		MODE_COOLING  = 3'd4
	} mode_t;

	// Input op codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// Drive event codes
	localparam logic [1:0] EV_NONE        = 2'd0;
	localparam logic [1:0] EV_STOP_FAULT  = 2'd1;
	localparam logic [1:0] EV_FAULT_CLEAR = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_TOTAL_CYCLES  = 3'd0;
	localparam logic [2:0] REG_TEST_SPEED    = 3'd1;
	localparam logic [2:0] REG_SPEED_FLOOR   = 3'd2;
	localparam logic [2:0] REG_SPEED_CEILING = 3'd3;
	localparam logic [2:0] REG_SPEED_SPREAD  = 3'd4;
	localparam logic [2:0] REG_RUN_TICKS     = 3'd5;
	localparam logic [2:0] REG_STOP_TICKS    = 3'd6;
	localparam logic [2:0] REG_TIME_SPREAD   = 3'd7;

	// LCG and stop time constants
	localparam logic [31:0] LCG_MUL = 32'd1664525;
	localparam logic [31:0] LCG_ADD = 32'd1013904223;
	localparam logic signed [17:0] STOP_OFFSET = -18'sd1000;

	// Remainder unit: one quotient bit per cycle over the 16-bit dividend
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Controller to datapath
	typedef struct packed {
		logic capture;   // latch input item
		logic step_en;   // apply non-random state update
		logic mix;       // advance LCG, load divider
		logic div_step;  // one remainder bit
		logic save;      // use finished draw
		logic sel;       // 0 stop time draw, 1 speed draw
		logic out_load;  // load output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_cycle;
		logic div_done;
	} dp_stat_t;

endpackage

FILE: rtl/msts_dp.sv
`timescale 1ns / 1ps

module msts_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  msts_pkg::dp_cmd_t   cmd,
	output msts_pkg::dp_stat_t  stat,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          op,
	input  logic                test_enable,
	input  logic                stall_fault,
	input  logic                any_fault,
	input  logic                drive_in_fault,
	input  logic [31:0]         entropy,
	output logic signed [15:0]  speed_request,
	output logic                speed_write,
	output logic [1:0]          drive_event,
	output logic [2:0]          seq_mode,
	output logic [15:0]         success_total,
	output logic [15:0]         fail_total,
	output logic                test_done
);

	// Configuration registers
	logic [15:0]        total_cycles_q;
	logic signed [15:0] test_speed_q;
	logic signed [15:0] speed_floor_q;
	logic signed [15:0] speed_ceiling_q;
	logic [13:0]        speed_spread_q;
	logic [15:0]        run_ticks_q;
	logic [14:0]        stop_ticks_q;
	logic [13:0]        time_spread_q;

	// Sequencer state
	msts_pkg::mode_t mode_q;
	logic [15:0]     timer_q;
	logic [15:0]     stop_time_q;
	logic [15:0]     succ_q;
	logic [15:0]     fail_q;
	logic            valid_q;
	logic [31:0]     seed_q;

	// Captured item
	logic [1:0]  op_q;
	logic        en_q;
	logic        stall_q;
	logic        anyf_q;
	logic        drvf_q;
	logic [31:0] ent_q;

	// Per-item result
	logic signed [15:0] res_speed_q;
	logic               res_wr_q;
	logic [1:0]         res_ev_q;
	logic               res_done_q;

	// Remainder unit
	logic [15:0]                    dvd_q;
	logic [14:0]                    rem_q;
	logic [msts_pkg::DIV_CNT_W-1:0] cnt_q;

	// Step logic outputs
	msts_pkg::mode_t n_mode;
	logic [15:0]     n_timer;
	logic [15:0]     n_succ;
	logic [15:0]     n_fail;
	logic            n_valid;
	logic            n_wr;
	logic [1:0]      n_ev;
	logic            n_done;
	logic            n_need;
	logic [15:0]     timer_inc;
	logic [16:0]     count_sum;

	logic [31:0]        seed_n;
	logic [13:0]        half;
	logic [14:0]        span;
	logic [15:0]        trial;
	logic signed [16:0] draw_r;
	logic signed [17:0] st_raw;
	logic [15:0]        st_limit;
	logic [15:0]        st_clamped;
	logic signed [15:0] spd_wrap;
	logic signed [15:0] spd_floor;
	logic signed [15:0] spd_clamped;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_cycles_q  <= 16'd0;
			test_speed_q    <= 16'sd0;
			speed_floor_q   <= 16'sd0;
			speed_ceiling_q <= 16'sd32767;
			speed_spread_q  <= 14'd0;
			run_ticks_q     <= 16'd8000;
			stop_ticks_q    <= 15'd6000;
			time_spread_q   <= 14'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				msts_pkg::REG_TOTAL_CYCLES:  total_cycles_q  <= cfg_data;
				msts_pkg::REG_TEST_SPEED:    test_speed_q    <= cfg_data;
				msts_pkg::REG_SPEED_FLOOR:   speed_floor_q   <= cfg_data;
				msts_pkg::REG_SPEED_CEILING: speed_ceiling_q <= cfg_data;
				msts_pkg::REG_SPEED_SPREAD:  speed_spread_q  <= cfg_data[13:0];
				msts_pkg::REG_RUN_TICKS:     run_ticks_q     <= cfg_data;
				msts_pkg::REG_STOP_TICKS:    stop_ticks_q    <= cfg_data[14:0];
				msts_pkg::REG_TIME_SPREAD:   time_spread_q   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			en_q    <= test_enable;
			stall_q <= stall_fault;
			anyf_q  <= any_fault;
			drvf_q  <= drive_in_fault;
			ent_q   <= entropy;
		end
	end

	// Tick / command decision, no random draw involved
	assign timer_inc = timer_q + 16'd1;
	assign count_sum = {1'b0, succ_q} + {1'b0, fail_q};

	always_comb begin
		n_mode  = mode_q;
		n_timer = timer_q;
		n_succ  = succ_q;
		n_fail  = fail_q;
		n_valid = valid_q;
		n_wr    = 1'b0;
		n_ev    = msts_pkg::EV_NONE;
		n_done  = 1'b0;
		n_need  = 1'b0;
		case (op_q)
			msts_pkg::OP_START: begin
				n_mode  = msts_pkg::MODE_STOPPING;
				n_timer = 16'd0;
				n_succ  = 16'd0;
				n_fail  = 16'd0;
				n_valid = 1'b0;
			end
			msts_pkg::OP_STOP: begin
				n_mode = msts_pkg::MODE_DISABLED;
			end
			msts_pkg::OP_TICK: begin
				if (mode_q != msts_pkg::MODE_DISABLED) begin
					if (!en_q) begin
						n_ev = msts_pkg::EV_STOP_FAULT;
						n_wr = 1'b1;
					end else if (stall_q && valid_q) begin
						n_valid = 1'b0;
						n_fail  = fail_q + 16'd1;
						n_mode  = msts_pkg::MODE_RECOVER;
						n_timer = 16'd0;
						n_ev    = msts_pkg::EV_STOP_FAULT;
						n_wr    = 1'b1;
					end else begin
						case (mode_q)
							msts_pkg::MODE_RUNNING: begin
								n_timer = timer_inc;
								if (timer_inc >= run_ticks_q) begin
									n_mode  = msts_pkg::MODE_STOPPING;
									n_timer = 16'd0;
									n_ev    = msts_pkg::EV_STOP_FAULT;
									n_succ  = succ_q + {15'd0, valid_q};
									n_wr    = 1'b1;
								end
							end
							msts_pkg::MODE_STOPPING: begin
								n_timer = timer_inc;
								if (timer_inc >= stop_time_q) begin
									if (total_cycles_q != 16'd0 &&
									    count_sum >= {1'b0, total_cycles_q}) begin
										n_mode = msts_pkg::MODE_DISABLED;
										n_done = 1'b1;
									end else begin
										n_need = 1'b1;
									end
								end
							end
							msts_pkg::MODE_RECOVER: begin
								if (!anyf_q) begin
									n_mode  = msts_pkg::MODE_COOLING;
									n_timer = 16'd0;
								end
							end
							msts_pkg::MODE_COOLING: begin
								n_timer = timer_inc;
								if (timer_inc >= {2'b0, stop_ticks_q[14:1]})
									n_need = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	assign stat.need_cycle = n_need;
	assign stat.div_done   = (cnt_q == msts_pkg::DIV_CNT_W'(msts_pkg::DIV_STEPS - 1));

	// LCG advance with entropy mixed in
	assign seed_n = (seed_q ^ ent_q) * msts_pkg::LCG_MUL + msts_pkg::LCG_ADD;

	// Remainder by 2*half+1, one bit per cycle
	assign half  = cmd.sel ? speed_spread_q : time_spread_q;
	assign span  = {half, 1'b1};
	assign trial = {rem_q, dvd_q[15]};

	// Finished draw and clamps
	assign draw_r     = $signed({2'b00, rem_q}) - $signed({3'b000, half});
	assign st_raw     = $signed({draw_r[16], draw_r}) + msts_pkg::STOP_OFFSET;
	assign st_limit   = {stop_ticks_q, 1'b0};
	assign st_clamped = st_raw[17] ? 16'd0 :
	                    (st_raw > $signed({2'b00, st_limit})) ? st_limit : st_raw[15:0];
	assign spd_wrap    = test_speed_q + draw_r[15:0];
	assign spd_floor   = (spd_wrap < speed_floor_q) ? speed_floor_q : spd_wrap;
	assign spd_clamped = (spd_floor > speed_ceiling_q) ? speed_ceiling_q : spd_floor;

	// Sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= msts_pkg::MODE_DISABLED;
			timer_q     <= 16'd0;
			stop_time_q <= 16'd0;
			succ_q      <= 16'd0;
			fail_q      <= 16'd0;
			valid_q     <= 1'b0;
			seed_q      <= 32'd0;
		end else begin
			if (cmd.step_en) begin
				mode_q  <= n_mode;
				timer_q <= n_timer;
				succ_q  <= n_succ;
				fail_q  <= n_fail;
				valid_q <= n_valid;
			end
			if (cmd.mix)
				seed_q <= seed_n;
			if (cmd.save && !cmd.sel)
				stop_time_q <= st_clamped;
			// second draw done: enter a new cycle
			if (cmd.save && cmd.sel) begin
				mode_q  <= msts_pkg::MODE_RUNNING;
				timer_q <= 16'd0;
				valid_q <= 1'b1;
			end
		end
	end

	// Divider registers
	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			dvd_q <= seed_n[31:16];
			rem_q <= 15'd0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= (trial >= {1'b0, span}) ? 15'(trial - {1'b0, span}) : trial[14:0];
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Per-item result fields
	always_ff @(posedge clk) begin
		if (cmd.step_en) begin
			res_speed_q <= 16'sd0;
			res_wr_q    <= n_wr;
			res_ev_q    <= n_ev;
			res_done_q  <= n_done;
		end else if (cmd.save && cmd.sel) begin
			res_speed_q <= spd_clamped;
			res_wr_q    <= 1'b1;
			res_ev_q    <= drvf_q ? msts_pkg::EV_FAULT_CLEAR : msts_pkg::EV_NONE;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			speed_request <= res_speed_q;
			speed_write   <= res_wr_q;
			drive_event   <= res_ev_q;
			seq_mode      <= mode_q;
			success_total <= succ_q;
			fail_total    <= fail_q;
			test_done     <= res_done_q;
		end
	end

	// New cycle always lands in running mode inside the stop time window
	a_cycle_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.save && cmd.sel |=> mode_q == msts_pkg::MODE_RUNNING &&
		stop_time_q <= {stop_ticks_q, 1'b0})
		else $error("new cycle state wrong");

	// Partial remainder stays below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < $past(span))
		else $error("remainder out of range");

endmodule

FILE: rtl/msts_ctrl.sv
`timescale 1ns / 1ps

module msts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output msts_pkg::dp_cmd_t  cmd,
	input  msts_pkg::dp_stat_t stat
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EVAL = 6'b000010,
		ST_MIX  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_SAVE = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   sel_q;
	logic   sel_n;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_n = state_q;
		sel_n   = sel_q;
		cmd     = '0;
		cmd.sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid)
					state_n = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.step_en = 1'b1;
				sel_n       = 1'b0;
				state_n     = stat.need_cycle ? ST_MIX : ST_OUT;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_n = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done)
					state_n = ST_SAVE;
			end
			ST_SAVE: begin
				cmd.save = 1'b1;
				if (sel_q) begin
					state_n = ST_OUT;
				end else begin
					sel_n   = 1'b1;
					state_n = ST_MIX;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			sel_q   <= sel_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// An accepted item is always evaluated next
	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EVAL)
		else $error("accepted item not evaluated");

	// A draw is used only after a full remainder run
	a_save_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SAVE |-> $past(state_q) == ST_DIV && $past(stat.div_done))
		else $error("draw saved early");

	// The output register never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid_q || out_ready)
		else $error("result overwritten");

endmodule

FILE: rtl/motor_start_test_sequencer_top.sv
`timescale 1ns / 1ps

// Motor start test sequencer.
// Input channel (in_valid/in_ready): one item per 10 ms tick or per start/stop
// command, with fault flags and an entropy word. Every item gives exactly one
// result on the output channel (out_valid/out_ready).
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// eight setup registers; cfg_ready is always high. Write only while idle.
// A command or an ordinary tick is evaluated and its result loaded into the
// output register. A tick that opens a new test cycle first makes two LCG
// draws, each a multiply step and then a run of the bit-serial remainder
// unit. The next item is accepted in the cycle after the result is loaded
// into the output register, so the block takes no new item before the last
// one's result is loaded.
// A stalled receiver holds the result in the output register; the block
// still takes and works the next item and waits only to hand its result over.
// Reset clears the mode, timer, counts, seed and loads the default setup.

module motor_start_test_sequencer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic               test_enable,
	input  logic               stall_fault,
	input  logic               any_fault,
	input  logic               drive_in_fault,
	input  logic [31:0]        entropy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] speed_request,
	output logic               speed_write,
	output logic [1:0]         drive_event,
	output logic [2:0]         seq_mode,
	output logic [15:0]        success_total,
	output logic [15:0]        fail_total,
	output logic               test_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	msts_pkg::dp_cmd_t  cmd;
	msts_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	msts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	msts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.test_enable    (test_enable),
		.stall_fault    (stall_fault),
		.any_fault      (any_fault),
		.drive_in_fault (drive_in_fault),
		.entropy        (entropy),
		.speed_request  (speed_request),
		.speed_write    (speed_write),
		.drive_event    (drive_event),
		.seq_mode       (seq_mode),
		.success_total  (success_total),
		.fail_total     (fail_total),
		.test_done      (test_done)
	);

endmodule

FILE: dv/msts_tracker.sv
`timescale 1ns / 1ps

module msts_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         op,
	input  logic               test_enable,
	input  logic               stall_fault,
	input  logic               any_fault,
	input  logic               drive_in_fault,
	input  logic [31:0]        entropy,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] speed_request,
	input  logic               speed_write,
	input  logic [1:0]         drive_event,
	input  logic [2:0]         seq_mode,
	input  logic [15:0]        success_total,
	input  logic [15:0]        fail_total,
	input  logic               test_done,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output int                 errors,
	output int                 open_items
);

	// What one step of the sequencer reports on the output channel
	typedef struct packed {
		logic signed [15:0] speed;
		logic               write;
		logic [1:0]         event_code;
		logic [2:0]         mode;
		logic [15:0]        successes;
		logic [15:0]        failures;
		logic               done;
	} step_report_t;

	step_report_t reports_due[$];
	step_report_t want;

	// Setup register copies
	logic [15:0]        total_cycles_r;
	logic signed [15:0] test_speed_r;
	logic signed [15:0] speed_floor_r;
	logic signed [15:0] speed_ceiling_r;
	logic [13:0]        speed_spread_r;
	logic [15:0]        run_ticks_r;
	logic [14:0]        stop_ticks_r;
	logic [13:0]        time_spread_r;

	// Sequencer state
	msts_pkg::mode_t mode_now;
	logic [15:0]     timer;
	logic [15:0]     stop_time;
	logic [15:0]     successes;
	logic [15:0]     failures;
	logic            cycle_live;
	logic [31:0]     seed;

	// Mix entropy into the LCG, advance it, fold the top half into [-half, half]
	function automatic int random_offset(input logic [31:0] mix_in, input logic [13:0] half);
		int span;
		span = 2 * int'(half) + 1;
		seed = msts_pkg::LCG_MUL * (seed ^ mix_in) + msts_pkg::LCG_ADD;
		return (int'(seed[31:16]) % span) - int'(half);
	endfunction

	// New test cycle: stop time draw first, then the speed draw
	function automatic void open_cycle(input logic [31:0] mix_in, input logic fault_drive,
			inout step_report_t rep);
		int                 stop_pick;
		int                 speed_pick;
		logic signed [15:0] wrapped;
		mode_now = msts_pkg::MODE_RUNNING;
		timer = '0;
		cycle_live = 1'b1;
		stop_pick = int'(msts_pkg::STOP_OFFSET) + random_offset(mix_in, time_spread_r);
		if (stop_pick < 0)
			stop_pick = 0;
		else if (stop_pick > 2 * int'(stop_ticks_r))
			stop_pick = 2 * int'(stop_ticks_r);
		stop_time = stop_pick[15:0];
		speed_pick = int'(test_speed_r) + random_offset(mix_in, speed_spread_r);
		wrapped = speed_pick[15:0];
		speed_pick = int'(wrapped);
		// floor first, so the ceiling wins when they cross
		if (speed_pick < int'(speed_floor_r))
			speed_pick = int'(speed_floor_r);
		if (speed_pick > int'(speed_ceiling_r))
			speed_pick = int'(speed_ceiling_r);
		rep.speed = speed_pick[15:0];
		rep.write = 1'b1;
		if (fault_drive)
			rep.event_code = msts_pkg::EV_FAULT_CLEAR;
	endfunction

	// Apply one input item to the state copy and return its report
	function automatic step_report_t sequence_step(input logic [1:0] code, input logic enable,
			input logic stall, input logic fault_any, input logic fault_drive,
			input logic [31:0] mix_in);
		step_report_t rep;
		logic [16:0]  cycles_seen;
		rep = '0;
		if (code == msts_pkg::OP_START) begin
			mode_now = msts_pkg::MODE_STOPPING;
			timer = '0;
			successes = '0;
			failures = '0;
			cycle_live = 1'b0;
		end else if (code == msts_pkg::OP_STOP) begin
			mode_now = msts_pkg::MODE_DISABLED;
		end else if (code == msts_pkg::OP_TICK && mode_now != msts_pkg::MODE_DISABLED) begin
			if (!enable) begin
				rep.event_code = msts_pkg::EV_STOP_FAULT;
				rep.write = 1'b1;
			end else if (stall && cycle_live) begin
				// stall while the current cycle is live ends it as a failure
				cycle_live = 1'b0;
				failures = failures + 16'd1;
				mode_now = msts_pkg::MODE_RECOVER;
				timer = '0;
				rep.event_code = msts_pkg::EV_STOP_FAULT;
				rep.write = 1'b1;
			end else begin
				case (mode_now)
					msts_pkg::MODE_RUNNING: begin
						timer = timer + 16'd1;
						if (timer >= run_ticks_r) begin
							mode_now = msts_pkg::MODE_STOPPING;
							timer = '0;
							rep.event_code = msts_pkg::EV_STOP_FAULT;
							rep.write = 1'b1;
							if (cycle_live)
								successes = successes + 16'd1;
						end
					end
					msts_pkg::MODE_STOPPING: begin
						timer = timer + 16'd1;
						if (timer >= stop_time) begin
							cycles_seen = {1'b0, successes} + {1'b0, failures};
							if (total_cycles_r != 0 && cycles_seen >= total_cycles_r) begin
								mode_now = msts_pkg::MODE_DISABLED;
								rep.done = 1'b1;
							end else begin
								open_cycle(mix_in, fault_drive, rep);
							end
						end
					end
					msts_pkg::MODE_RECOVER: begin
						if (!fault_any) begin
							mode_now = msts_pkg::MODE_COOLING;
							timer = '0;
						end
					end
					msts_pkg::MODE_COOLING: begin
						timer = timer + 16'd1;
						if (timer >= (stop_ticks_r >> 1))
							open_cycle(mix_in, fault_drive, rep);
					end
					default: ;
				endcase
			end
		end
		rep.mode = mode_now;
		rep.successes = successes;
		rep.failures = failures;
		return rep;
	endfunction

	// Report one differing field
	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	// Watch the channels; results first, then the new item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_cycles_r = 16'd0;
			test_speed_r = 16'sd0;
			speed_floor_r = 16'sd0;
			speed_ceiling_r = 16'sd32767;
			speed_spread_r = 14'd0;
			run_ticks_r = 16'd8000;
			stop_ticks_r = 15'd6000;
			time_spread_r = 14'd5000;
			mode_now = msts_pkg::MODE_DISABLED;
			timer = '0;
			stop_time = '0;
			successes = '0;
			failures = '0;
			cycle_live = 1'b0;
			seed = '0;
			reports_due.delete();
			errors = 0;
			open_items = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: result with nothing expected, seq_mode %0d", $time,
						seq_mode);
					errors++;
				end else begin
					want = reports_due.pop_front();
					check_field("speed_request", int'($signed(want.speed)),
						int'(speed_request));
					check_field("speed_write", int'(want.write), int'(speed_write));
					check_field("drive_event", int'(want.event_code), int'(drive_event));
					check_field("seq_mode", int'(want.mode), int'(seq_mode));
					check_field("success_total", int'(want.successes), int'(success_total));
					check_field("fail_total", int'(want.failures), int'(fail_total));
					check_field("test_done", int'(want.done), int'(test_done));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					msts_pkg::REG_TOTAL_CYCLES:  total_cycles_r = cfg_data;
					msts_pkg::REG_TEST_SPEED:    test_speed_r = cfg_data;
					msts_pkg::REG_SPEED_FLOOR:   speed_floor_r = cfg_data;
					msts_pkg::REG_SPEED_CEILING: speed_ceiling_r = cfg_data;
					msts_pkg::REG_SPEED_SPREAD:  speed_spread_r = cfg_data[13:0];
					msts_pkg::REG_RUN_TICKS:     run_ticks_r = cfg_data;
					msts_pkg::REG_STOP_TICKS:    stop_ticks_r = cfg_data[14:0];
					msts_pkg::REG_TIME_SPREAD:   time_spread_r = cfg_data[13:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				reports_due.push_back(sequence_step(op, test_enable, stall_fault, any_fault,
					drive_in_fault, entropy));
			open_items = reports_due.size();
		end
	end

endmodule

FILE: dv/motor_start_test_sequencer_top_test.sv
`timescale 1ns / 1ps

module motor_start_test_sequencer_top_test;

	// op code the block ignores
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = msts_pkg::OP_TICK;
	logic               test_enable = 1'b0;
	logic               stall_fault = 1'b0;
	logic               any_fault = 1'b0;
	logic               drive_in_fault = 1'b0;
	logic [31:0]        entropy = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] speed_request;
	logic               speed_write;
	logic [1:0]         drive_event;
	logic [2:0]         seq_mode;
	logic [15:0]        success_total;
	logic [15:0]        fail_total;
	logic               test_done;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = msts_pkg::REG_TOTAL_CYCLES;
	logic [15:0]        cfg_data = '0;
	int                 errors;
	int                 open_items;
	logic               calm = 1'b0;
	msts_pkg::mode_t    seen_mode = msts_pkg::MODE_DISABLED;

	always #10 clk = ~clk;

	motor_start_test_sequencer_top dut (.*);

	msts_tracker tracker (.*);

	// Receiver stalls at random unless in a calm stretch
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 19);
	end

	// Mode from the latest result, used to restart a stopped test
	always @(posedge clk) begin
		if (out_valid && out_ready)
			seen_mode <= msts_pkg::mode_t'(seq_mode);
	end

	// Hard stop if the run hangs
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Present one item and hold it until taken
	task automatic send_item(input logic [1:0] code, input logic enable, input logic stall,
			input logic fault_any, input logic fault_drive, input logic [31:0] mix_in);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		test_enable <= enable;
		stall_fault <= stall;
		any_fault <= fault_any;
		drive_in_fault <= fault_drive;
		entropy <= mix_in;
		do @(posedge clk); while (!in_ready);
	endtask

	// Tick item with random entropy
	task automatic tick(input logic enable, input logic stall, input logic fault_any,
			input logic fault_drive);
		send_item(msts_pkg::OP_TICK, enable, stall, fault_any, fault_drive, $urandom());
	endtask

	// Stop sending and wait until every result is back and the block is quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (open_items != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_setup(input logic [15:0] total, input logic [15:0] speed,
			input logic [15:0] floor_v, input logic [15:0] ceil_v, input logic [15:0] spread,
			input logic [15:0] run, input logic [15:0] stop, input logic [15:0] t_spread);
		write_reg(msts_pkg::REG_TOTAL_CYCLES, total);
		write_reg(msts_pkg::REG_TEST_SPEED, speed);
		write_reg(msts_pkg::REG_SPEED_FLOOR, floor_v);
		write_reg(msts_pkg::REG_SPEED_CEILING, ceil_v);
		write_reg(msts_pkg::REG_SPEED_SPREAD, spread);
		write_reg(msts_pkg::REG_RUN_TICKS, run);
		write_reg(msts_pkg::REG_STOP_TICKS, stop);
		write_reg(msts_pkg::REG_TIME_SPREAD, t_spread);
	endtask

	// Mostly healthy ticks, with faults, stalls and commands mixed in
	task automatic random_run(input int count);
		int         taken;
		int         pick;
		logic [1:0] code;
		taken = 0;
		while (taken < count) begin
			pick = $urandom_range(99);
			if (seen_mode == msts_pkg::MODE_DISABLED && pick < 50)
				code = msts_pkg::OP_START;
			else if (pick < 2)
				code = msts_pkg::OP_STOP;
			else if (pick < 3)
				code = OP_SPARE;
			else if (pick < 5)
				code = msts_pkg::OP_START;
			else
				code = msts_pkg::OP_TICK;
			// ticks into a stopped test do nothing
			if (code != msts_pkg::OP_TICK || seen_mode != msts_pkg::MODE_DISABLED)
				taken++;
			send_item(code, $urandom_range(99) >= 4, $urandom_range(99) < 5,
				1'($urandom_range(1)), $urandom_range(99) < 30, $urandom());
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Default setup: commands and idle ticks only
		send_item(msts_pkg::OP_TICK, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
		send_item(OP_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(msts_pkg::OP_STOP, 1'b0, 1'b0, 1'b0, 1'b0, $urandom());
		send_item(msts_pkg::OP_START, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		tick(1'b0, 1'b0, 1'b0, 1'b0);
		send_item(msts_pkg::OP_STOP, 1'b1, 1'b0, 1'b0, 1'b0, $urandom());
		settle();

		// Short cycles with full-range speed draws and a completion after three
		load_setup(16'd3, 16'sd32767, 16'h8000, 16'sd32767, 16'd16383, 16'd1, 16'd4, 16'd1010);
		send_item(msts_pkg::OP_START, 1'b1, 1'b0, 1'b0, 1'b0, $urandom());
		send_item(msts_pkg::OP_TICK, 1'b1, 1'b1, 1'b0, 1'b1, 32'h0000_0000);
		send_item(OP_SPARE, 1'b1, 1'b0, 1'b0, 1'b0, $urandom());
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b1, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b1, 1'b0);
		tick(1'b0, 1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0, 1'b0);
		send_item(msts_pkg::OP_STOP, 1'b1, 1'b0, 1'b0, 1'b0, $urandom());
		send_item(msts_pkg::OP_START, 1'b1, 1'b0, 1'b0, 1'b0, $urandom());
		send_item(msts_pkg::OP_TICK, 1'b1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
		tick(1'b1, 1'b1, 1'b0, 1'b0);
		send_item(msts_pkg::OP_STOP, 1'b1, 1'b0, 1'b0, 1'b0, $urandom());
		settle();

		// Long calm stretch, no idling on either side
		load_setup(16'd0, 16'($urandom_range(65535)), 16'h8000, 16'sd32767, 16'd16383, 16'd3,
			16'd6, 16'd1100);
		calm <= 1'b1;
		random_run(150);
		settle();
		calm <= 1'b0;

		// Crossed limits, no speed spread, zero run and stop times
		load_setup(16'd65535, 16'h8000, 16'sd5000, -16'sd5000, 16'd0, 16'd0, 16'd0, 16'd16383);
		random_run(100);
		settle();

		// Moderate speeds, completion after a handful of cycles
		load_setup(16'd7, 16'sd1000, 16'sd0, 16'sd20000, 16'd300, 16'd5, 16'd10, 16'd1040);
		random_run(150);
		settle();

		// Longest run and stop settings
		load_setup(16'd1, 16'sd32767, 16'h8000, 16'sd32767, 16'd8000, 16'd65535, 16'd32767,
			16'd0);
		random_run(40);
		settle();

		// Random limits and spreads
		load_setup(16'd20, 16'($urandom_range(65535)), -16'sd20000, 16'sd20000,
			16'($urandom_range(16383)), 16'd2, 16'd3, 16'(1005 + $urandom_range(200)));
		random_run(110);
		settle();

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: files.f
rtl/msts_pkg.sv
rtl/msts_dp.sv
rtl/msts_ctrl.sv
rtl/motor_start_test_sequencer_top.sv
dv/msts_tracker.sv
dv/motor_start_test_sequencer_top_test.sv
